// File: rtl/bptg_pkg.sv
// bptg_pkg: shared types, constants and the gray decode function for the
// bit-plane transpose / gray decoder. No dependencies.
package bptg_pkg;

	localparam int CHANNELS_DEF        = 128;
	localparam int HITS_DEF            = 15;
	localparam int WORDS_PER_FRAME_DEF = 1924;

	localparam int NUM_CHIPS = 4;
	localparam int CHIP_W    = 2;
	localparam int WORD_W    = 16;
	localparam int ADC_W     = 12;
	localparam int CHAN_W    = 7;
	localparam int SLOT_W    = 4;
	localparam int QDEPTH    = 2;
	localparam int QAW       = 1;
	localparam int QCW       = 2;

	localparam logic [CHIP_W-1:0] LAST_CHIP = CHIP_W'(NUM_CHIPS - 1);

	typedef logic [ADC_W-1:0] adc_t;

	// one completed group of four words, ready for decode
	typedef struct packed {
		logic [NUM_CHIPS-1:0]            flag;
		logic [NUM_CHIPS-1:0][ADC_W-1:0] gray;
		logic [CHAN_W-1:0]               chan;
		logic [SLOT_W-1:0]               slot;
	} group_t;

	// each binary bit is the xor of all gray bits at and above it
	function automatic adc_t gray_to_bin(input adc_t g);
		adc_t b;
		b = '0;
		for (int i = 0; i < ADC_W; i++) begin
			b[i] = ^(g >> i);
		end
		return b;
	endfunction

endpackage

// File: rtl/bitplane_transpose_gray_decoder.sv
// bitplane_transpose_gray_decoder: top level, front transposer, group queue
// and decode back end. Depends on bptg_pkg, bptg_front, bptg_queue, bptg_back.
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall   frame_start, raw_byte
//  out      from block out_valid / out_stall chip_index, channel_index, hit_slot,
//                                            adc_value, flag_bit, last_of_group
//
// one byte per cycle in while in_stall is low; sixteen data bytes complete a group
// of four words, which the back end emits as four results. a group goes into the
// queue, then chip by chip into the output register. the two-entry group queue
// parts the sides; in_stall is high only while it is full.
// reset clears frame state, counters, queue pointers and output valid.
module bitplane_transpose_gray_decoder import bptg_pkg::*; #(
	parameter int CHANNELS        = CHANNELS_DEF,
	parameter int HITS            = HITS_DEF,
	parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               frame_start,
	input  logic [7:0]         raw_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CHIP_W-1:0]  chip_index,
	output logic [CHAN_W-1:0]  channel_index,
	output logic [SLOT_W-1:0]  hit_slot,
	output logic [ADC_W-1:0]   adc_value,
	output logic               flag_bit,
	output logic               last_of_group
);
	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	group_t push_data;
	group_t head;

	bptg_front #(
		.CHANNELS        (CHANNELS),
		.HITS            (HITS),
		.WORDS_PER_FRAME (WORDS_PER_FRAME)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_start (frame_start),
		.raw_byte    (raw_byte),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	bptg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.empty     (q_empty),
		.full      (q_full),
		.head      (head)
	);

	bptg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.chip_index    (chip_index),
		.channel_index (channel_index),
		.hit_slot      (hit_slot),
		.adc_value     (adc_value),
		.flag_bit      (flag_bit),
		.last_of_group (last_of_group)
	);

endmodule

// File: rtl/bptg_front.sv
// bptg_front: takes bytes, transposes nibble bits into four 16-bit words and
// tracks channel and hit slot. Depends on bptg_pkg.
module bptg_front import bptg_pkg::*; #(
	parameter int CHANNELS        = CHANNELS_DEF,
	parameter int HITS            = HITS_DEF,
	parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic         frame_start,
	input  logic [7:0]   raw_byte,
	input  logic         q_full,
	output logic         push,
	output group_t       push_data
);
	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HW  = $clog2(HITS + 1);
	localparam int WCW = $clog2(WORDS_PER_FRAME + 1);

	logic                            active_q;
	logic [3:0]                      bitpos_q;
	logic [WCW-1:0]                  wcnt_q;
	logic [CW-1:0]                   chan_q;
	logic [HW-1:0]                   slot_q;
	logic [NUM_CHIPS-1:0][WORD_W-1:0] word_q;
	logic [NUM_CHIPS-1:0][WORD_W-1:0] word_nx;

	logic        accept;
	logic        data_take;
	logic        word_done;
	logic        emit;
	logic [31:0] chan_wide;
	logic [31:0] slot_wide;

	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign data_take = accept && !frame_start && active_q;
	assign word_done = data_take && (bitpos_q == 4'hf);
	assign emit      = (slot_q < HW'(HITS));
	assign push      = word_done && emit;

	// chip k takes nibble bit 3-k, msb first
	always_comb begin
		for (int k = 0; k < NUM_CHIPS; k++) begin
			word_nx[k] = {word_q[k][WORD_W-2:0], raw_byte[NUM_CHIPS-1-k]};
		end
	end

	assign chan_wide = 32'(chan_q);
	assign slot_wide = 32'(slot_q);

	always_comb begin
		for (int k = 0; k < NUM_CHIPS; k++) begin
			push_data.flag[k] = word_nx[k][WORD_W-1];
			push_data.gray[k] = word_nx[k][ADC_W-1:0];
		end
		push_data.chan = chan_wide[CHAN_W-1:0];
		push_data.slot = slot_wide[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bitpos_q <= '0;
			wcnt_q   <= '0;
			chan_q   <= '0;
			slot_q   <= '0;
			word_q   <= '0;
		end else if (accept) begin
			if (frame_start) begin
				active_q <= 1'b1;
				bitpos_q <= '0;
				wcnt_q   <= '0;
				chan_q   <= '0;
				slot_q   <= '0;
				word_q   <= '0;
			end else if (active_q) begin
				bitpos_q <= bitpos_q + 4'd1;
				if (bitpos_q == 4'hf) begin
					word_q <= '0;
					wcnt_q <= wcnt_q + WCW'(1);
					if (wcnt_q == WCW'(WORDS_PER_FRAME - 1)) begin
						active_q <= 1'b0;
					end
					if (emit) begin
						if (chan_q == CW'(CHANNELS - 1)) begin
							chan_q <= '0;
							slot_q <= slot_q + HW'(1);
						end else begin
							chan_q <= chan_q + CW'(1);
						end
					end
				end else begin
					word_q <= word_nx;
				end
			end
		end
	end

endmodule

// File: rtl/bptg_queue.sv
// bptg_queue: short queue of completed word groups between front and back.
// Depends on bptg_pkg.
module bptg_queue import bptg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_data,
	input  logic   pop,
	output logic   empty,
	output logic   full,
	output group_t head
);
	group_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCW'(QDEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/bptg_back.sv
// bptg_back: walks the four chips of the head group, gray decodes each word
// and holds the result in an output register. Depends on bptg_pkg.
module bptg_back import bptg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  group_t             head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CHIP_W-1:0]  chip_index,
	output logic [CHAN_W-1:0]  channel_index,
	output logic [SLOT_W-1:0]  hit_slot,
	output logic [ADC_W-1:0]   adc_value,
	output logic               flag_bit,
	output logic               last_of_group
);
	logic [CHIP_W-1:0] chip_q;
	logic              valid_q;
	logic              load;

	// output slot free and a group waiting
	assign load = (!valid_q || !out_stall) && !q_empty;
	assign pop  = load && (chip_q == LAST_CHIP);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			chip_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				chip_q  <= chip_q + CHIP_W'(1);
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chip_index    <= chip_q;
			channel_index <= head.chan;
			hit_slot      <= head.slot;
			adc_value     <= gray_to_bin(head.gray[chip_q]);
			flag_bit      <= head.flag[chip_q];
			last_of_group <= (chip_q == LAST_CHIP);
		end
	end

endmodule

// File: verif/bitplane_transpose_gray_decoder_test.sv
// bitplane_transpose_gray_decoder_test: self-checking bench for the bit-plane
// transposer and gray decoder; drives readout bytes, predicts decoded words and
// checks every output transfer. Depends on bptg_pkg and bitplane_transpose_gray_decoder.
module bitplane_transpose_gray_decoder_test;
	import bptg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS         = CHANNELS_DEF;
	localparam int HITS             = HITS_DEF;
	localparam int WORDS_PER_FRAME  = WORDS_PER_FRAME_DEF;
	localparam int BYTES_PER_WORD   = WORD_W;
	localparam int QUIET_LIMIT      = 2000;
	localparam int HOLDOFF_CYCLES   = 300;
	localparam int TAIL_CYCLES      = 16;
	localparam int RANDOM_ITEMS     = 20;
	localparam int RANDOM_RESULTS   = 4;
	localparam int PATTERN_LEN      = 11;

	typedef struct packed {
		logic [CHIP_W-1:0] chip;
		logic [CHAN_W-1:0] chan;
		logic [SLOT_W-1:0] slot;
		logic [ADC_W-1:0]  adc;
		logic              flag;
		logic              last;
	} decoded_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               frame_start = 1'b0;
	logic [7:0]         raw_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CHIP_W-1:0]  chip_index;
	logic [CHAN_W-1:0]  channel_index;
	logic [SLOT_W-1:0]  hit_slot;
	logic [ADC_W-1:0]   adc_value;
	logic               flag_bit;
	logic               last_of_group;

	// predicted transposer state
	logic [3:0]         bits_taken;
	int unsigned        words_done;
	logic [WORD_W-1:0]  chip_words [NUM_CHIPS];
	logic               frame_open;

	decoded_word_t      pending_words [$];
	int                 words_made = 0;
	int                 error_count = 0;

	// sender and receiver idling controls
	int                 gap_limit = 0;
	int                 burst_left = 0;
	logic               stall_on = 1'b0;
	logic [PATTERN_LEN-1:0] stall_pattern = '0;
	int                 holdoff_request = 0;

	bitplane_transpose_gray_decoder #(
		.CHANNELS(CHANNELS),
		.HITS(HITS),
		.WORDS_PER_FRAME(WORDS_PER_FRAME)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_start(frame_start),
		.raw_byte(raw_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chip_index(chip_index),
		.channel_index(channel_index),
		.hit_slot(hit_slot),
		.adc_value(adc_value),
		.flag_bit(flag_bit),
		.last_of_group(last_of_group)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// binary bit i is the running xor of gray bits from the top down to i
	function automatic logic [ADC_W-1:0] gray_decode(input logic [ADC_W-1:0] g);
		logic [ADC_W-1:0] b;
		logic run;
		b = '0;
		run = 1'b0;
		for (int i = ADC_W - 1; i >= 0; i--) begin
			run = run ^ g[i];
			b[i] = run;
		end
		return b;
	endfunction

	function automatic void clear_assembly();
		bits_taken = '0;
		words_done = 0;
		for (int k = 0; k < NUM_CHIPS; k++) begin
			chip_words[k] = '0;
		end
	endfunction

	// advance the predicted state by one accepted byte
	function automatic void transpose_byte(input logic start, input logic [7:0] data);
		decoded_word_t w;
		if (start) begin
			clear_assembly();
			frame_open = 1'b1;
			return;
		end
		if (!frame_open) begin
			return;
		end
		for (int k = 0; k < NUM_CHIPS; k++) begin
			chip_words[k] = {chip_words[k][WORD_W-2:0], data[NUM_CHIPS-1-k]};
		end
		bits_taken = bits_taken + 4'd1;
		if (bits_taken != 4'd0) begin
			return;
		end
		if (words_done < CHANNELS * HITS) begin
			for (int k = 0; k < NUM_CHIPS; k++) begin
				w.chip = CHIP_W'(k);
				w.chan = CHAN_W'(words_done % CHANNELS);
				w.slot = SLOT_W'(words_done / CHANNELS);
				w.adc  = gray_decode(chip_words[k][ADC_W-1:0]);
				w.flag = chip_words[k][WORD_W-1];
				w.last = (CHIP_W'(k) == LAST_CHIP);
				pending_words.push_back(w);
				words_made++;
			end
		end
		for (int k = 0; k < NUM_CHIPS; k++) begin
			chip_words[k] = '0;
		end
		words_done++;
		if (words_done >= WORDS_PER_FRAME) begin
			frame_open = 1'b0;
		end
	endfunction

	// one input transfer, with burst gaps when enabled
	task automatic push_byte(input logic start, input logic [7:0] data);
		if (gap_limit != 0 && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, gap_limit)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_valid <= 1'b1;
		frame_start <= start;
		raw_byte <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		transpose_byte(start, data);
	endtask

	// sender pauses until every predicted word has come out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic push_random_bytes(input int count);
		repeat (count) push_byte(1'b0, 8'($urandom));
	endtask

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$error("%s mismatch: expected %0d actual %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin : word_check
		decoded_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				error_count++;
				$error("output transfer with nothing expected: chip %0d channel %0d",
					chip_index, channel_index);
			end else begin
				want = pending_words.pop_front();
				compare_field("chip_index", 16'(want.chip), 16'(chip_index));
				compare_field("channel_index", 16'(want.chan), 16'(channel_index));
				compare_field("hit_slot", 16'(want.slot), 16'(hit_slot));
				compare_field("adc_value", 16'(want.adc), 16'(adc_value));
				compare_field("flag_bit", 16'(want.flag), 16'(flag_bit));
				compare_field("last_of_group", 16'(want.last), 16'(last_of_group));
			end
		end
	end

	initial begin : receiver
		int hold_count;
		int phase;
		hold_count = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (holdoff_request > 0) begin
				hold_count = holdoff_request;
				holdoff_request = 0;
			end
			if (hold_count > 0) begin
				hold_count--;
				out_stall <= 1'b1;
			end else if (stall_on) begin
				out_stall <= stall_pattern[phase];
				phase = (phase + 1) % PATTERN_LEN;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("simulation failed");
		$finish;
	end

	function automatic void new_stall_pattern();
		// bit 0 stays clear so the receiver never stalls forever
		stall_pattern = PATTERN_LEN'($urandom) & ~PATTERN_LEN'(1);
	endfunction

	// data with no frame open, then a restarted frame with hand-picked words
	task automatic test_directed_words();
		logic [WORD_W-1:0] words [NUM_CHIPS];
		logic [3:0] nib;
		gap_limit = 0;
		stall_on = 1'b0;
		push_byte(1'b0, 8'h0F);
		push_byte(1'b0, 8'hF0);
		push_byte(1'b1, 8'hFF);
		push_random_bytes(5);
		push_byte(1'b1, 8'h00);
		// all ones, gray 0x800 (max value), all zeros, mixed with flag clear
		words[0] = 16'hFFFF;
		words[1] = 16'h8800;
		words[2] = 16'h0000;
		words[3] = 16'h7A5C;
		for (int j = 0; j < BYTES_PER_WORD; j++) begin
			for (int k = 0; k < NUM_CHIPS; k++) begin
				nib[NUM_CHIPS-1-k] = words[k][WORD_W-1-j];
			end
			push_byte(1'b0, {4'($urandom), nib});
		end
		wait_for_results();
	endtask

	// long receiver hold-off fills the queue; then a pause in mid word
	task automatic test_backpressure();
		gap_limit = 0;
		stall_on = 1'b0;
		push_byte(1'b1, 8'($urandom));
		holdoff_request = HOLDOFF_CYCLES;
		push_random_bytes(2 * BYTES_PER_WORD);
		push_random_bytes(3);
		wait_for_results();
		stall_on = 1'b1;
		new_stall_pattern();
		gap_limit = 3;
		push_random_bytes(9 + BYTES_PER_WORD);
		wait_for_results();
	endtask

	task automatic test_random_frames();
		int sent;
		int made_base;
		sent = 0;
		made_base = words_made;
		while (sent < RANDOM_ITEMS || words_made - made_base < RANDOM_RESULTS) begin
			gap_limit = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			stall_on = ($urandom_range(0, 3) != 0);
			new_stall_pattern();
			case ($urandom_range(0, 7))
				0: begin
					// noise with stray header marks
					repeat ($urandom_range(1, 6)) begin
						push_byte($urandom_range(0, 3) == 0, 8'($urandom));
						sent++;
					end
				end
				1: begin
					// word cut short by a new header
					push_byte(1'b1, 8'($urandom));
					repeat ($urandom_range(1, BYTES_PER_WORD - 1)) begin
						push_byte(1'b0, 8'($urandom));
						sent++;
					end
					push_byte(1'b1, 8'($urandom));
					sent += 2;
				end
				default: begin
					push_byte(1'b1, 8'($urandom));
					sent++;
					repeat ($urandom_range(1, 3)) begin
						push_random_bytes(BYTES_PER_WORD);
						sent += BYTES_PER_WORD;
					end
				end
			endcase
		end
		wait_for_results();
	endtask

	initial begin
		frame_open = 1'b0;
		clear_assembly();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_words();
		test_backpressure();
		test_random_frames();
		wait_for_results();
		stall_on = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: bitplane_transpose_gray_decoder.f
rtl/bptg_pkg.sv
rtl/bptg_front.sv
rtl/bptg_queue.sv
rtl/bptg_back.sv
rtl/bitplane_transpose_gray_decoder.sv
verif/bitplane_transpose_gray_decoder_test.sv
